### rtl/bpfs_pkg.sv
package bpfs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_A_X   = 3'd0,
    REG_LIGHT_A_Y   = 3'd1,
    REG_LIGHT_A_Z   = 3'd2,
    REG_LIGHT_B_X   = 3'd3,
    REG_LIGHT_B_Y   = 3'd4,
    REG_LIGHT_B_Z   = 3'd5,
    REG_LIGHT_POWER = 3'd6,
    REG_SHININESS   = 3'd7
  } cfg_reg_t;

  // Vector normalizer: five setup stages, one root bit per stage, numerator
  // stage, one quotient bit per stage, sign stage.
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 16;
  localparam int U3_LAT     = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // Intensity divider: one quotient bit per stage.
  localparam int IDIV_STEPS = 40;
  localparam int SQ_W       = 34;

  localparam int POW_STEPS  = 8;

  // Stage numbers of the main pipeline, counted from the accepting edge.
  localparam int ST_D   = 1;
  localparam int ST_SQ  = 3;
  localparam int ST_I   = ST_SQ + IDIV_STEPS;
  localparam int ST_U1  = ST_D + U3_LAT;
  localparam int ST_HS  = ST_U1 + 1;
  localparam int ST_CL  = ST_HS + 1;
  localparam int ST_U2  = ST_HS + U3_LAT;
  localparam int ST_CH  = ST_U2 + 2;
  localparam int ST_PW  = ST_CH + POW_STEPS;
  localparam int ST_M1  = ST_PW + 1;
  localparam int ST_M2  = ST_PW + 2;
  localparam int ST_OUT = ST_PW + 6;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [40:0] ICAP     = 41'h100_0000_0000;
  localparam logic [15:0] KS_Q8    = 16'd51813;
  localparam logic [50:0] AMB2_Q24 = 51'd427819008;

  typedef logic signed [17:0] uin_t;
  typedef logic signed [15:0] ucomp_t;
  typedef logic [40:0]        inten_t;

endpackage

### rtl/bpfs_if.sv
interface bpfs_frag_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [7:0]         refl_r;
  logic [7:0]         refl_g;
  logic [7:0]         refl_b;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  refl_r, refl_g, refl_b, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                refl_r, refl_g, refl_b, output ready);
endinterface

interface bpfs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_r;
  logic [7:0] out_g;
  logic [7:0] out_b;
  logic       clipped;

  modport source (output valid, out_r, out_g, out_b, clipped, input ready);
  modport sink (input valid, out_r, out_g, out_b, clipped, output ready);
endinterface

### rtl/blinn_phong_fragment_shader.sv
// Throughput: one fragment per cycle while the pixel output is not stalled; the
// normalizers (one root bit and one quotient bit per stage) and the 40-stage
// intensity divider are fully pipelined. A stalled pixel output holds every
// stage in place, so nothing is lost. Synchronous reset clears all valid bits
// and loads the default lights, power 500 and shininess 150.
module blinn_phong_fragment_shader import bpfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bpfs_frag_if.sink             frag,
  bpfs_pix_if.source            pix
);

  localparam int NU_LEN   = ST_U2 - ST_U1;
  localparam int CL_LEN   = ST_PW - ST_CL;
  localparam int I_LEN    = ST_PW - ST_I;
  localparam int REFL_LEN = ST_M2;

  logic signed [15:0] lpos [2][3];
  logic [15:0]        light_power;
  logic [7:0]         shininess;

  logic              adv;
  logic [ST_OUT:1]   vld;

  logic signed [15:0] pin [3];
  logic signed [15:0] nin [3];

  uin_t         d1 [2][3];
  uin_t         np1 [3];
  uin_t         n1 [3];
  logic [31:0]  sqp [2][3];
  logic [SQ_W-1:0] sq3 [2];
  inten_t       inten [2];

  ucomp_t nu [3];
  ucomp_t vu [3];
  ucomp_t lu [2][3];
  ucomp_t hu [2][3];
  uin_t   hs [2][3];
  logic signed [31:0] clp [2][3];
  logic signed [31:0] chp [2][3];
  logic [16:0] cl [2];
  logic [16:0] ch [2];

  ucomp_t      nu_line   [NU_LEN][3];
  logic [16:0] cl_line   [CL_LEN][2];
  inten_t      i_line    [I_LEN][2];
  logic [7:0]  refl_line [REFL_LEN][3];

  logic [16:0] pw_res  [POW_STEPS][2];
  logic [16:0] pw_base [POW_STEPS][2];
  logic [16:0] res_in  [POW_STEPS][2];
  logic [16:0] base_in [POW_STEPS][2];
  logic [16:0] sp [2];

  logic [37:0] dlo [2];
  logic [36:0] dhi [2];
  logic [37:0] slo [2];
  logic [36:0] shi [2];
  logic [40:0] dbase [2];
  logic [40:0] sbase [2];
  logic [48:0] dr  [2][3];
  logic [48:0] dr4 [2][3];
  logic [36:0] sklo [2];
  logic [35:0] skhi [2];
  logic [47:0] sterm [2];
  logic [50:0] acc [3];
  logic [26:0] rnd [3];

  logic [7:0] out_ch [3];
  logic       clip;

  function automatic logic [16:0] cos_fin(input logic signed [31:0] p0,
                                          input logic signed [31:0] p1,
                                          input logic signed [31:0] p2);
    logic signed [33:0] dot;
    logic [33:0]        c;
    dot = 34'(p0) + 34'(p1) + 34'(p2);
    c   = (34'(dot) + 34'd2048) >> 12;
    if (dot <= 34'sd0) return '0;
    if (c > 34'(ONE_Q16)) return ONE_Q16;
    return c[16:0];
  endfunction

  function automatic logic [16:0] mulq16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd32768;
    return p[32:16];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lpos[0][0]  <= 16'sd5120;
      lpos[0][1]  <= 16'sd5120;
      lpos[0][2]  <= 16'sd2560;
      lpos[1][0]  <= -16'sd5120;
      lpos[1][1]  <= 16'sd5120;
      lpos[1][2]  <= -16'sd2560;
      light_power <= 16'd500;
      shininess   <= 8'd150;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_LIGHT_A_X:   lpos[0][0]  <= cfg_wdata;
        REG_LIGHT_A_Y:   lpos[0][1]  <= cfg_wdata;
        REG_LIGHT_A_Z:   lpos[0][2]  <= cfg_wdata;
        REG_LIGHT_B_X:   lpos[1][0]  <= cfg_wdata;
        REG_LIGHT_B_Y:   lpos[1][1]  <= cfg_wdata;
        REG_LIGHT_B_Z:   lpos[1][2]  <= cfg_wdata;
        REG_LIGHT_POWER: light_power <= cfg_wdata;
        REG_SHININESS:   shininess   <= cfg_wdata[7:0];
        default:         light_power <= light_power;
      endcase
    end
  end

  // The whole pipeline moves as one; it only holds when the pixel beat waits.
  assign adv        = !vld[ST_OUT] || pix.ready;
  assign frag.ready = adv && !rst;
  assign pix.valid  = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_OUT-1:1], frag.valid};
    end
  end

  assign pin[0] = frag.pos_x;
  assign pin[1] = frag.pos_y;
  assign pin[2] = frag.pos_z;
  assign nin[0] = frag.norm_x;
  assign nin[1] = frag.norm_y;
  assign nin[2] = frag.norm_z;

  bpfs_unit3 u_norm_n  (.clk(clk), .en(adv), .vin(n1),    .uout(nu));
  bpfs_unit3 u_norm_v  (.clk(clk), .en(adv), .vin(np1),   .uout(vu));
  bpfs_unit3 u_norm_la (.clk(clk), .en(adv), .vin(d1[0]), .uout(lu[0]));
  bpfs_unit3 u_norm_lb (.clk(clk), .en(adv), .vin(d1[1]), .uout(lu[1]));
  bpfs_unit3 u_norm_ha (.clk(clk), .en(adv), .vin(hs[0]), .uout(hu[0]));
  bpfs_unit3 u_norm_hb (.clk(clk), .en(adv), .vin(hs[1]), .uout(hu[1]));

  bpfs_idiv u_idiv_a (.clk(clk), .en(adv), .power(light_power), .sq(sq3[0]),
                      .inten(inten[0]));
  bpfs_idiv u_idiv_b (.clk(clk), .en(adv), .power(light_power), .sq(sq3[1]),
                      .inten(inten[1]));

  // Right-to-left square and multiply, one exponent bit per stage.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      res_in[0][l]  = ONE_Q16;
      base_in[0][l] = ch[l];
      for (int p = 1; p < POW_STEPS; p++) begin
        res_in[p][l]  = pw_res[p-1][l];
        base_in[p][l] = pw_base[p-1][l];
      end
      // The specular term only counts where the Lambert term is positive.
      sp[l] = (cl_line[CL_LEN-1][l] != 17'd0) ? pw_res[POW_STEPS-1][l] : 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        for (int l = 0; l < 2; l++) begin
          d1[l][c]  <= uin_t'(lpos[l][c]) - uin_t'(pin[c]);
          sqp[l][c] <= 32'(36'(d1[l][c]) * 36'(d1[l][c]));
          hs[l][c]  <= uin_t'(lu[l][c]) + uin_t'(vu[c]);
          clp[l][c] <= nu[c] * lu[l][c];
          chp[l][c] <= nu_line[NU_LEN-1][c] * hu[l][c];
        end
        np1[c] <= -uin_t'(pin[c]);
        n1[c]  <= uin_t'(nin[c]);
      end
      for (int l = 0; l < 2; l++) begin
        sq3[l] <= SQ_W'(sqp[l][0]) + SQ_W'(sqp[l][1]) + SQ_W'(sqp[l][2]);
        cl[l]  <= cos_fin(clp[l][0], clp[l][1], clp[l][2]);
        ch[l]  <= cos_fin(chp[l][0], chp[l][1], chp[l][2]);
      end

      refl_line[0][0] <= frag.refl_r;
      refl_line[0][1] <= frag.refl_g;
      refl_line[0][2] <= frag.refl_b;
      for (int k = 1; k < REFL_LEN; k++) refl_line[k] <= refl_line[k-1];
      nu_line[0] <= nu;
      for (int k = 1; k < NU_LEN; k++) nu_line[k] <= nu_line[k-1];
      cl_line[0] <= cl;
      for (int k = 1; k < CL_LEN; k++) cl_line[k] <= cl_line[k-1];
      i_line[0] <= inten;
      for (int k = 1; k < I_LEN; k++) i_line[k] <= i_line[k-1];

      for (int p = 0; p < POW_STEPS; p++) begin
        for (int l = 0; l < 2; l++) begin
          pw_res[p][l]  <= shininess[p] ? mulq16(res_in[p][l], base_in[p][l])
                                        : res_in[p][l];
          pw_base[p][l] <= mulq16(base_in[p][l], base_in[p][l]);
        end
      end

      // Intensity times cosine and specular term, two partial products each.
      for (int l = 0; l < 2; l++) begin
        dlo[l] <= 38'(i_line[I_LEN-1][l][20:0]) * 38'(cl_line[CL_LEN-1][l]);
        dhi[l] <= 37'(i_line[I_LEN-1][l][40:21]) * 37'(cl_line[CL_LEN-1][l]);
        slo[l] <= 38'(i_line[I_LEN-1][l][20:0]) * 38'(sp[l]);
        shi[l] <= 37'(i_line[I_LEN-1][l][40:21]) * 37'(sp[l]);
        dbase[l] <= 41'(((58'(dhi[l]) << 21) + 58'(dlo[l]) + 58'd32768) >> 16);
        sbase[l] <= 41'(((58'(shi[l]) << 21) + 58'(slo[l]) + 58'd32768) >> 16);
        for (int c = 0; c < 3; c++) begin
          dr[l][c]  <= 49'(dbase[l]) * 49'(refl_line[REFL_LEN-1][c]);
          dr4[l][c] <= dr[l][c];
        end
        sklo[l]  <= 37'(sbase[l][20:0]) * 37'(KS_Q8);
        skhi[l]  <= 36'(sbase[l][40:21]) * 36'(KS_Q8);
        sterm[l] <= 48'(((57'(skhi[l]) << 21) + 57'(sklo[l]) + 57'd128) >> 8);
      end

      for (int c = 0; c < 3; c++) begin
        acc[c] <= AMB2_Q24 + 51'(dr4[0][c]) + 51'(dr4[1][c])
                  + 51'(sterm[0]) + 51'(sterm[1]);
      end
      for (int c = 0; c < 3; c++) begin
        out_ch[c] <= (rnd[c] > 27'd255) ? 8'd255 : rnd[c][7:0];
      end
      clip <= (rnd[0] > 27'd255) || (rnd[1] > 27'd255) || (rnd[2] > 27'd255);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = 27'((acc[c] + 51'h80_0000) >> 24);
    end
  end

  assign pix.out_r   = out_ch[0];
  assign pix.out_g   = out_ch[1];
  assign pix.out_b   = out_ch[2];
  assign pix.clipped = clip;

endmodule

### rtl/bpfs_unit3.sv
module bpfs_unit3 import bpfs_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  uin_t   vin  [3],
  output ucomp_t uout [3]
);

  localparam int M_LEN  = SQRT_STEPS + 3;
  localparam int SD_LEN = SQRT_STEPS + DIV_STEPS + 5;

  logic [17:0] mag_a [3];
  logic [2:0]  sgn_a;
  logic [17:0] mag_b [3];
  logic [4:0]  sh_b;
  logic [17:0] mx;
  logic [4:0]  sh;
  logic [29:0] m_line [M_LEN][3];
  logic [3:0]  sd_line [SD_LEN];
  logic [59:0] sqr_d [3];
  logic [61:0] s_e;

  logic [61:0] q_s    [SQRT_STEPS];
  logic [31:0] q_rem  [SQRT_STEPS];
  logic [30:0] q_root [SQRT_STEPS];
  logic [61:0] s_in    [SQRT_STEPS];
  logic [31:0] rem_in  [SQRT_STEPS];
  logic [30:0] root_in [SQRT_STEPS];
  logic [33:0] cur     [SQRT_STEPS];
  logic [33:0] trial   [SQRT_STEPS];

  logic [44:0] num_n [3];
  logic [30:0] r_n;

  logic [30:0] v_rem [DIV_STEPS][3];
  logic [15:0] v_q   [DIV_STEPS][3];
  logic [15:0] v_num [DIV_STEPS][3];
  logic [30:0] v_r   [DIV_STEPS];
  logic [30:0] d_rem_in [DIV_STEPS][3];
  logic [15:0] d_q_in   [DIV_STEPS][3];
  logic [15:0] d_num_in [DIV_STEPS][3];
  logic [30:0] d_r_in   [DIV_STEPS];
  logic [31:0] d_cur    [DIV_STEPS][3];
  logic        d_ge     [DIV_STEPS][3];

  // Shift count that brings the largest magnitude into [2^29, 2^30).
  always_comb begin
    mx = mag_a[0];
    if (mag_a[1] > mx) mx = mag_a[1];
    if (mag_a[2] > mx) mx = mag_a[2];
    sh = '0;
    for (int b = 0; b < 18; b++) begin
      if (mx[b]) sh = 5'(29 - b);
    end
  end

  // Square root: one result bit per stage, two radicand bits brought down.
  always_comb begin
    s_in[0]    = s_e;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      s_in[j]    = q_s[j-1];
      rem_in[j]  = q_rem[j-1];
      root_in[j] = q_root[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      cur[j]   = {rem_in[j], s_in[j][2*(SQRT_STEPS-1-j) +: 2]};
      trial[j] = {1'b0, root_in[j], 2'b01};
    end
  end

  // Rounded quotient m * 2^14 / r: one quotient bit per stage.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_rem_in[0][i] = 31'(num_n[i][44:16]);
      d_num_in[0][i] = num_n[i][15:0];
      d_q_in[0][i]   = '0;
    end
    d_r_in[0] = r_n;
    for (int t = 1; t < DIV_STEPS; t++) begin
      for (int i = 0; i < 3; i++) begin
        d_rem_in[t][i] = v_rem[t-1][i];
        d_num_in[t][i] = v_num[t-1][i];
        d_q_in[t][i]   = v_q[t-1][i];
      end
      d_r_in[t] = v_r[t-1];
    end
    for (int t = 0; t < DIV_STEPS; t++) begin
      for (int i = 0; i < 3; i++) begin
        d_cur[t][i] = {d_rem_in[t][i], d_num_in[t][i][15]};
        d_ge[t][i]  = d_cur[t][i] >= {1'b0, d_r_in[t]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn_a[i] <= vin[i][17];
        mag_a[i] <= vin[i][17] ? 18'(-vin[i]) : 18'(vin[i]);
        mag_b[i] <= mag_a[i];
        m_line[0][i] <= 30'(mag_b[i]) << sh_b;
        sqr_d[i] <= 60'(m_line[0][i]) * 60'(m_line[0][i]);
        num_n[i] <= 45'({m_line[M_LEN-1][i], 14'b0}) + 45'(q_root[SQRT_STEPS-1][30:1]);
      end
      sh_b <= sh;
      sd_line[0] <= {mx == 18'd0, sgn_a};
      for (int k = 1; k < M_LEN; k++) m_line[k] <= m_line[k-1];
      for (int k = 1; k < SD_LEN; k++) sd_line[k] <= sd_line[k-1];
      s_e <= 62'(sqr_d[0]) + 62'(sqr_d[1]) + 62'(sqr_d[2]);

      for (int j = 0; j < SQRT_STEPS; j++) begin
        q_s[j] <= s_in[j];
        if (cur[j] >= trial[j]) begin
          q_rem[j]  <= 32'(cur[j] - trial[j]);
          q_root[j] <= {root_in[j][29:0], 1'b1};
        end else begin
          q_rem[j]  <= cur[j][31:0];
          q_root[j] <= {root_in[j][29:0], 1'b0};
        end
      end
      r_n <= q_root[SQRT_STEPS-1];

      for (int t = 0; t < DIV_STEPS; t++) begin
        for (int i = 0; i < 3; i++) begin
          v_rem[t][i] <= d_ge[t][i] ? 31'(d_cur[t][i] - {1'b0, d_r_in[t]})
                                    : d_cur[t][i][30:0];
          v_q[t][i]   <= {d_q_in[t][i][14:0], d_ge[t][i]};
          v_num[t][i] <= {d_num_in[t][i][14:0], 1'b0};
        end
        v_r[t] <= d_r_in[t];
      end

      for (int i = 0; i < 3; i++) begin
        if (sd_line[SD_LEN-1][3]) begin
          uout[i] <= '0;
        end else if (sd_line[SD_LEN-1][i]) begin
          uout[i] <= -ucomp_t'(v_q[DIV_STEPS-1][i]);
        end else begin
          uout[i] <= ucomp_t'(v_q[DIV_STEPS-1][i]);
        end
      end
    end
  end

endmodule

### rtl/bpfs_idiv.sv
module bpfs_idiv import bpfs_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [15:0]     power,
  input  logic [SQ_W-1:0] sq,
  output inten_t          inten
);

  logic [SQ_W-1:0]       st_rem [IDIV_STEPS];
  logic [SQ_W-1:0]       st_sq  [IDIV_STEPS];
  logic [IDIV_STEPS-1:0] st_q   [IDIV_STEPS];
  logic                  st_sat [IDIV_STEPS];
  logic [SQ_W-1:0]       rem_in [IDIV_STEPS];
  logic [SQ_W-1:0]       sq_in  [IDIV_STEPS];
  logic [IDIV_STEPS-1:0] q_in   [IDIV_STEPS];
  logic                  sat_in [IDIV_STEPS];
  logic [SQ_W:0]         cur    [IDIV_STEPS];
  logic                  ge     [IDIV_STEPS];

  // When power >= sq the quotient is at least 2^40 and the result saturates;
  // otherwise power itself is the first partial remainder.
  always_comb begin
    rem_in[0] = SQ_W'(power);
    sq_in[0]  = sq;
    q_in[0]   = '0;
    sat_in[0] = SQ_W'(power) >= sq;
    for (int t = 1; t < IDIV_STEPS; t++) begin
      rem_in[t] = st_rem[t-1];
      sq_in[t]  = st_sq[t-1];
      q_in[t]   = st_q[t-1];
      sat_in[t] = st_sat[t-1];
    end
    for (int t = 0; t < IDIV_STEPS; t++) begin
      cur[t] = {rem_in[t], 1'b0};
      ge[t]  = cur[t] >= {1'b0, sq_in[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < IDIV_STEPS; t++) begin
        st_rem[t] <= ge[t] ? SQ_W'(cur[t] - {1'b0, sq_in[t]}) : cur[t][SQ_W-1:0];
        st_sq[t]  <= sq_in[t];
        st_q[t]   <= {q_in[t][IDIV_STEPS-2:0], ge[t]};
        st_sat[t] <= sat_in[t];
      end
    end
  end

  assign inten = st_sat[IDIV_STEPS-1] ? ICAP : {1'b0, st_q[IDIV_STEPS-1]};

endmodule
